FILE: sv/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies.
package lfu_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int CAP_W            = 5;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] item_key;
        logic [30:0] item_value;
    } lfu_in_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lfu_out_t;

    // One table entry as held in RAM
    typedef struct packed {
        logic [31:0] key;
        logic [30:0] data;
        logic [31:0] count;
        logic [31:0] stamp;
    } lfu_entry_t;

    localparam int ENTRY_W = $bits(lfu_entry_t);

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } lfu_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lfu_stat_t;

endpackage

FILE: sv/lfu_cache_table.sv
// LFU cache table, top level: key-value cache with least-frequently-used
// replacement, oldest-stamp tie break.
//
// Channels: s_ (valid/ready) carries op, key and value of one request;
// m_ (valid/ready) returns hit, read value and eviction details, one result
// per request. cfg_ (valid/ready) writes the capacity register; cfg_ready is
// always high. Capacity is to be written only while the block is idle; the
// block itself does not enforce it. One request is in flight at a time.
// The single read port of the entry RAM sets the steps: key match, free
// slot and victim search share one pass over all entries, one per cycle,
// then a drain state takes the last read word and a decide state writes
// back and loads the result register. s_ready returns the cycle after the
// write-back.
// Reset (aresetn, synchronous, active low) clears all valid bits, the stamp
// counter and the result valid flag, and sets capacity to 16.
// A stalled m_ready holds the result; the next request is still taken and
// scanned, then waits at write-back with s_ready low until the result goes.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
module lfu_cache_table import lfu_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lfu_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lfu_out_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    lfu_cmd_t  cmd;
    lfu_stat_t stat;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lfu_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

FILE: sv/lfu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lfu_ctrl.sv
// Sequencer for the LFU cache table: accept, scan, drain, commit.
// Depends on lfu_pkg.
module lfu_ctrl import lfu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lfu_stat_t stat,
    output lfu_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // last read word is folded in here
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.commit = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/lfu_datapath.sv
// Datapath of the LFU cache table: entry RAM, valid bits, scan accumulators,
// commit logic and result register. Depends on lfu_pkg and lfu_ram.
module lfu_datapath import lfu_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfu_cmd_t         cmd,
    output lfu_stat_t        stat,
    input  lfu_in_t          s_data,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             m_ready,
    output logic             m_valid,
    output lfu_out_t         m_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    lfu_in_t          item_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [31:0]      stamp_reg;
    logic [CAPACITY-1:0] valid_reg;

    logic [IDX_W-1:0] scan_cnt_reg;
    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    logic [CNT_W-1:0] used_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    lfu_entry_t       found_entry_reg;
    logic             free_any_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             vict_any_reg;
    logic [IDX_W-1:0] vict_idx_reg;
    lfu_entry_t       vict_entry_reg;

    logic             m_valid_reg;
    lfu_out_t         m_data_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    lfu_entry_t       rd_entry;
    logic             ev_valid;
    logic             key_match;
    logic             better;

    logic [CMP_W-1:0] cap_raw;
    logic [CMP_W-1:0] cap_eff;
    logic             is_full;
    logic             cnt_sat;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    lfu_entry_t       wr_entry;
    logic             set_valid;
    logic             stamp_inc;
    lfu_out_t         res;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.commit & wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (cmd.scan),
        .raddr (scan_cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry  = lfu_entry_t'(ram_rdata);
    assign ev_valid  = valid_reg[eval_idx_reg];
    assign key_match = rd_entry.key == item_reg.item_key;
    // lowest count wins, oldest stamp on a tie; strict compare keeps lowest slot
    assign better    = {rd_entry.count, rd_entry.stamp}
                     < {vict_entry_reg.count, vict_entry_reg.stamp};

    assign stat.scan_last = scan_cnt_reg == IDX_W'(CAPACITY - 1);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign cap_raw = CMP_W'(capacity_reg);
    assign cap_eff = (cap_raw > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_raw;
    assign is_full = CMP_W'(used_reg) >= cap_eff;
    assign cnt_sat = found_entry_reg.count == COUNT_MAX;

    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = free_idx_reg;
        wr_entry.key   = item_reg.item_key;
        wr_entry.data  = item_reg.item_value;
        wr_entry.count = 32'd1;
        wr_entry.stamp = stamp_reg;
        set_valid      = 1'b0;
        stamp_inc      = 1'b0;
        res            = '0;
        priority if (found_reg) begin
            wr_en    = 1'b1;
            wr_addr  = found_idx_reg;
            wr_entry = found_entry_reg;
            res.hit  = 1'b1;
            if (!cnt_sat) begin
                wr_entry.count = found_entry_reg.count + 32'd1;
                wr_entry.stamp = stamp_reg;
                stamp_inc      = 1'b1;
            end
            if (item_reg.op == OP_PUT) begin
                wr_entry.data = item_reg.item_value;
            end else begin
                res.read_value = found_entry_reg.data;
            end
        end else if (item_reg.op == OP_GET || cap_eff == '0) begin
            // miss on get, or nothing may be stored
        end else if (is_full) begin
            wr_en           = 1'b1;
            wr_addr         = vict_idx_reg;
            stamp_inc       = 1'b1;
            res.evicted     = 1'b1;
            res.evicted_key = vict_entry_reg.key;
        end else begin
            wr_en     = 1'b1;
            wr_addr   = free_idx_reg;
            set_valid = 1'b1;
            stamp_inc = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            stamp_reg    <= '0;
            valid_reg    <= '0;
            scan_cnt_reg <= '0;
            eval_vld_reg <= 1'b0;
            used_reg     <= '0;
            found_reg    <= 1'b0;
            free_any_reg <= 1'b0;
            vict_any_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            eval_vld_reg <= cmd.scan;
            if (cmd.load) begin
                scan_cnt_reg <= '0;
                used_reg     <= '0;
                found_reg    <= 1'b0;
                free_any_reg <= 1'b0;
                vict_any_reg <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (eval_vld_reg) begin
                    if (ev_valid) begin
                        used_reg <= used_reg + CNT_W'(1);
                        if (key_match) begin
                            found_reg <= 1'b1;
                        end
                        vict_any_reg <= 1'b1;
                    end else begin
                        free_any_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit) begin
                if (stamp_inc) begin
                    stamp_reg <= stamp_reg + 32'd1;
                end
                if (set_valid) begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        eval_idx_reg <= scan_cnt_reg;
        if (eval_vld_reg && ev_valid) begin
            if (!found_reg && key_match) begin
                found_idx_reg   <= eval_idx_reg;
                found_entry_reg <= rd_entry;
            end
            if (!vict_any_reg || better) begin
                vict_idx_reg   <= eval_idx_reg;
                vict_entry_reg <= rd_entry;
            end
        end
        if (eval_vld_reg && !ev_valid && !free_any_reg) begin
            free_idx_reg <= eval_idx_reg;
        end
        if (cmd.commit) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/lfu_checker.sv
// Port-level checks for lfu_cache_table, attached by bind.
// Depends on lfu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfu_checker import lfu_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input lfu_in_t          s_data,
    input logic             m_valid,
    input logic             m_ready,
    input lfu_out_t         m_data,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CAP_W-1:0] cfg_data
);

    // a stalled result must hold
    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    // one request in flight: no second transfer straight after the first
    `CHK_ASSERT(a_one_inflight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken during a lookup")
    // reset empties the result register
    `CHK_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    // a hit never evicts
    `CHK_ASSERT(a_hit_no_evict, aclk, aresetn, m_valid |-> !(m_data.hit && m_data.evicted), "hit and eviction together")
    // miss reads zero, and no eviction means no evicted key
    `CHK_ASSERT(a_zero_fields, aclk, aresetn, m_valid |-> (m_data.hit || m_data.read_value == '0) && (m_data.evicted || m_data.evicted_key == '0), "stray result field")

endmodule

bind lfu_cache_table lfu_checker u_chk (.*);

FILE: dv/lfu_cache_table_tb.sv
// Self-checking testbench for lfu_cache_table: directed and random get/put traffic
// checked against a behavioural LFU table with oldest-stamp tie break.
// Depends on lfu_pkg and the lfu_cache_table RTL.
module lfu_cache_table_tb import lfu_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = CAPACITY_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    // Behavioural copy of the table; expected results queue in transfer order
    class lfu_scoreboard;
        bit             slot_live [SLOTS];
        bit [31:0]      slot_key  [SLOTS];
        bit [30:0]      slot_value[SLOTS];
        bit [31:0]      slot_uses [SLOTS];
        bit [31:0]      slot_stamp[SLOTS];
        bit [31:0]      stamp_next;
        bit [CAP_W-1:0] capacity;
        lfu_out_t       expected_q[$];
        int             errors;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            stamp_next = '0;
            capacity   = CAPACITY_RESET;
            errors     = 0;
        endfunction

        function void set_capacity(bit [CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit [31:0] take_stamp();
            bit [31:0] s;
            s = stamp_next;
            stamp_next = stamp_next + 32'd1;
            return s;
        endfunction

        function void note_request(lfu_in_t req);
            lfu_out_t rsp;
            int       hit_slot, free_slot, victim, live_count, limit;
            rsp        = '0;
            hit_slot   = -1;
            free_slot  = -1;
            victim     = -1;
            live_count = 0;
            limit      = (capacity > SLOTS) ? SLOTS : int'(capacity);
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_live[i]) begin
                    live_count++;
                    if (hit_slot < 0 && slot_key[i] == req.item_key)
                        hit_slot = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit_slot >= 0) begin
                // saturated count keeps its stamp as well
                if (slot_uses[hit_slot] != COUNT_MAX) begin
                    slot_uses[hit_slot]  = slot_uses[hit_slot] + 32'd1;
                    slot_stamp[hit_slot] = take_stamp();
                end
                rsp.hit = 1'b1;
                if (req.op == OP_GET)
                    rsp.read_value = slot_value[hit_slot];
                else
                    slot_value[hit_slot] = req.item_value;
            end else if (req.op == OP_PUT && limit != 0) begin
                // occupancy may exceed a lowered capacity: still one eviction per insert
                if (live_count >= limit) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!slot_live[i])
                            continue;
                        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                            (slot_uses[i] == slot_uses[victim] &&
                             slot_stamp[i] < slot_stamp[victim]))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        slot_live[victim] = 1'b0;
                        rsp.evicted       = 1'b1;
                        rsp.evicted_key   = slot_key[victim];
                        free_slot         = victim;
                    end
                end
                if (free_slot >= 0) begin
                    slot_live[free_slot]  = 1'b1;
                    slot_key[free_slot]   = req.item_key;
                    slot_value[free_slot] = req.item_value;
                    slot_uses[free_slot]  = 32'd1;
                    slot_stamp[free_slot] = take_stamp();
                end
            end
            expected_q.insert(expected_q.size(), rsp);
        endfunction

        function void flag(string field, bit [31:0] want, bit [31:0] got);
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        endfunction

        function void check_response(lfu_out_t got);
            lfu_out_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result transfer with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.hit != want.hit)
                flag("hit", want.hit, got.hit);
            if (got.read_value != want.read_value)
                flag("read_value", want.read_value, got.read_value);
            if (got.evicted != want.evicted)
                flag("evicted", want.evicted, got.evicted);
            if (got.evicted_key != want.evicted_key)
                flag("evicted_key", want.evicted_key, got.evicted_key);
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    lfu_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    lfu_out_t         m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    lfu_scoreboard sb = new();
    bit            no_idle  = 1'b0;
    bit            hold_req = 1'b0;
    bit [31:0]     key_pool[$];
    int            stall_cycles = 0;

    lfu_cache_table #(.CAPACITY(CAPACITY_DEFAULT)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(lfu_in_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        @(negedge aclk);
    endtask

    task automatic write_capacity(bit [CAP_W-1:0] v);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_capacity(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic take_result();
        int gap;
        if (hold_req) begin
            hold_req = 1'b0;
            gap = LONG_HOLD;
        end else begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
        end
        if (gap > 0) begin
            m_ready <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!m_valid);
        @(negedge aclk);
    endtask

    function automatic bit [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        if (r < 85 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    function automatic bit [30:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return 31'($urandom());
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_response(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        wait (aresetn);
        @(negedge aclk);
        forever take_result();
    end

    initial begin
        bit [CAP_W-1:0] cap;
        lfu_in_t        req;
        int             pool_size;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table, key and value extremes, update of a present key
        send_item(lfu_in_t'{OP_GET, 32'h0000_0000, 31'h0});
        send_item(lfu_in_t'{OP_PUT, 32'h0000_0000, 31'h0});
        send_item(lfu_in_t'{OP_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
        send_item(lfu_in_t'{OP_GET, 32'h0000_0000, 31'h7FFF_FFFF});
        send_item(lfu_in_t'{OP_GET, 32'hFFFF_FFFF, 31'h0});
        send_item(lfu_in_t'{OP_PUT, 32'h0000_0000, 31'h7FFF_FFFF});
        send_item(lfu_in_t'{OP_GET, 32'h0000_0000, 31'h0});
        for (int k = 1; k <= 4; k++)
            send_item(lfu_in_t'{OP_PUT, 32'(k), 31'(k * 'h1111)});
        send_item(lfu_in_t'{OP_GET, 32'd3, 31'h0});

        // capacity below occupancy: each new key evicts, ties go to the oldest stamp
        write_capacity(5'd3);
        send_item(lfu_in_t'{OP_PUT, 32'd100, 31'h55});
        send_item(lfu_in_t'{OP_PUT, 32'd101, 31'h66});
        send_item(lfu_in_t'{OP_GET, 32'd100, 31'h0});
        send_item(lfu_in_t'{OP_PUT, 32'd102, 31'h77});

        // zero capacity stores nothing new but present keys still answer
        write_capacity(5'd0);
        send_item(lfu_in_t'{OP_PUT, 32'd200, 31'h12});
        send_item(lfu_in_t'{OP_GET, 32'd200, 31'h0});
        send_item(lfu_in_t'{OP_GET, 32'd100, 31'h0});
        send_item(lfu_in_t'{OP_PUT, 32'd100, 31'h34});

        // capacity above the table size acts as the table size
        write_capacity(5'd31);
        send_item(lfu_in_t'{OP_PUT, 32'd300, 31'h56});
        send_item(lfu_in_t'{OP_GET, 32'd300, 31'h0});

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cap = 5'd1;
                1:       cap = 5'd16;
                2:       cap = 5'd31;
                3:       cap = 5'd5;
                4:       cap = 5'd0;
                5:       cap = 5'd8;
                default: cap = 5'($urandom_range(0, 31));
            endcase
            write_capacity(cap);
            no_idle = (p % 4 == 3);
            key_pool.delete();
            pool_size = $urandom_range(2, 24);
            repeat (pool_size) key_pool.insert(key_pool.size(), $urandom());
            if (p == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req.op         = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                req.item_key   = pick_key();
                req.item_value = pick_value();
                send_item(req);
                // sender goes quiet until every outstanding result is back
                if (p == 5 && n == PHASE_ITEMS / 2) begin
                    s_valid <= 1'b0;
                    while (sb.pending() != 0) @(negedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_ram.sv
sv/lfu_ctrl.sv
sv/lfu_datapath.sv
sv/lfu_cache_table.sv
sv/lfu_checker.sv
dv/lfu_cache_table_tb.sv
